>>> rtl/button_event_tracker_defines.svh
// Assertion macros used by the button event tracker top level.
`ifndef BUTTON_EVENT_TRACKER_DEFINES_SVH
`define BUTTON_EVENT_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define BET_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bet assertion failed");
// Checked on every edge, reset included.
`define BET_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("bet assertion failed");
`else
`define BET_ASSERT(label, prop)
`define BET_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> rtl/bet_pkg.sv
// Types and constants shared by the button event tracker modules.
`default_nettype none
package bet_pkg;

	localparam int ModeW    = 3;
	localparam int BitsW    = 8;
	localparam int TicksW   = 17;
	localparam int IndexW   = 5;
	localparam int TimeW    = 32;
	localparam int CountW   = 8;
	localparam int DivW     = 4;
	localparam int CfgIdxW  = 1;
	localparam int DirectButtons = 5;
	localparam int HatOffset     = 4;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_BIOS_MODE      = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_DEVICE_PRESENT = 1'b1;

	// Item operations
	typedef enum logic [ModeW-1:0] {
		OP_TICK        = 3'd0,
		OP_READ_STATE  = 3'd1,
		OP_READ_DOWN   = 3'd2,
		OP_READ_UP     = 3'd3,
		OP_READ_TIME   = 3'd4,
		OP_SET         = 3'd5,
		OP_FLUSH       = 3'd6
	} op_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_HOLD
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage
`default_nettype wire

>>> rtl/bet_ctrl.sv
// Controller state machine: item handshake and datapath sequencing.
`default_nettype none
module bet_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output bet_pkg::cmd_t      cmd
);
	import bet_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_HOLD;
			end
			S_HOLD: begin
				// result waits; the next item may enter as it leaves
				out_valid = 1'b1;
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = S_EXEC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/bet_datapath.sv
// Datapath: button state, counters, held time, sampling and read mux.
`default_nettype none
module bet_datapath #(
	parameter int BUTTON_COUNT = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bet_pkg::cmd_t                 cmd,
	input  wire logic                          cfg_wr,
	input  wire logic [bet_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic                          cfg_data,
	input  wire logic [bet_pkg::ModeW-1:0]     mode,
	input  wire logic [bet_pkg::BitsW-1:0]     button_bits,
	input  wire logic [bet_pkg::TicksW-1:0]    tick_count,
	input  wire logic [bet_pkg::IndexW-1:0]    button_index,
	input  wire logic                          set_state,
	input  wire logic [bet_pkg::TimeW-1:0]     set_time,
	input  wire logic [bet_pkg::CountW-1:0]    set_down_count,
	input  wire logic [bet_pkg::CountW-1:0]    set_up_count,
	output logic [bet_pkg::TimeW-1:0]          read_value
);
	import bet_pkg::*;

	localparam int BtnIdxW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

	// Item registers
	op_t                op_q;
	logic [BitsW-1:0]   bits_q;
	logic [TicksW-1:0]  ticks_q;
	logic [IndexW-1:0]  idx_q;
	logic               set_state_q;
	logic [TimeW-1:0]   set_time_q;
	logic [CountW-1:0]  set_down_q;
	logic [CountW-1:0]  set_up_q;
	logic [TimeW-1:0]   result_q;

	// Configuration
	logic bios_mode_q;
	logic present_q;

	// Per-button state
	logic [BUTTON_COUNT-1:0] prev_q;
	logic [BUTTON_COUNT-1:0] pressed_q;
	logic [BUTTON_COUNT-1:0] ovr_q;
	logic [TimeW-1:0]        held_q    [BUTTON_COUNT];
	logic [CountW-1:0]       down_q    [BUTTON_COUNT];
	logic [CountW-1:0]       up_q      [BUTTON_COUNT];
	logic [DivW-1:0]         div_q;
	logic [BitsW-1:0]        sample_q;

	logic [DivW-1:0]         div_inc;
	logic                    take_sample;
	logic [BitsW-1:0]        value;
	logic [BitsW:0]          hat_pos;
	logic [BUTTON_COUNT-1:0] lvl;
	logic                    in_range;
	logic                    read_ok;
	logic [BtnIdxW-1:0]      sel;
	logic [TimeW-1:0]        rd_c;

	// Capture the item and the result; payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= op_t'(mode);
			bits_q      <= button_bits;
			ticks_q     <= tick_count;
			idx_q       <= button_index;
			set_state_q <= set_state;
			set_time_q  <= set_time;
			set_down_q  <= set_down_count;
			set_up_q    <= set_up_count;
		end
		if (cmd.exec) begin
			result_q <= rd_c;
		end
	end

	assign read_value = result_q;

	// BIOS sampling: new byte on every eighth tick
	assign div_inc     = div_q + DivW'(1);
	assign take_sample = div_inc[DivW-1];
	always_comb begin
		if (bios_mode_q) begin
			value = take_sample ? bits_q : sample_q;
		end else begin
			value = bits_q;
		end
	end

	// Decode levels: direct bits, then hat positions
	assign hat_pos = {1'b0, value} + (BitsW+1)'(HatOffset);
	always_comb begin
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			if (i < DirectButtons) begin
				lvl[i] = value[i];
			end else begin
				lvl[i] = (hat_pos == (BitsW+1)'(i));
			end
		end
	end

	// Addressed button
	assign in_range = ({1'b0, idx_q} < (IndexW+1)'(BUTTON_COUNT));
	assign read_ok  = present_q && in_range;
	assign sel      = idx_q[BtnIdxW-1:0];

	// Read mux
	always_comb begin
		rd_c = '0;
		case (op_q)
			OP_READ_STATE: if (read_ok) rd_c = TimeW'(pressed_q[sel]);
			OP_READ_DOWN:  if (read_ok) rd_c = TimeW'(down_q[sel]);
			OP_READ_UP:    if (read_ok) rd_c = TimeW'(up_q[sel]);
			OP_READ_TIME:  if (read_ok) rd_c = held_q[sel];
			default:       rd_c = '0;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bios_mode_q <= 1'b0;
			present_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_BIOS_MODE:      bios_mode_q <= cfg_data;
				CFG_DEVICE_PRESENT: present_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Button state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			pressed_q <= '0;
			ovr_q     <= '0;
			div_q     <= '0;
			sample_q  <= '0;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				held_q[i] <= '0;
				down_q[i] <= '0;
				up_q[i]   <= '0;
			end
		end else if (cmd.exec) begin
			case (op_q)
				OP_TICK: begin
					if (bios_mode_q) begin
						div_q <= take_sample ? '0 : div_inc;
						if (take_sample) begin
							sample_q <= bits_q;
						end
					end
					for (int i = 0; i < BUTTON_COUNT; i++) begin
						if (!ovr_q[i]) begin
							if (prev_q[i] == lvl[i]) begin
								if (lvl[i]) begin
									held_q[i] <= held_q[i] + TimeW'(ticks_q);
								end
							end else begin
								if (lvl[i]) begin
									down_q[i]    <= down_q[i] + CountW'(1);
									pressed_q[i] <= 1'b1;
								end else begin
									// adds nothing when a flush cleared pressed
									up_q[i]      <= up_q[i] + CountW'(pressed_q[i]);
									pressed_q[i] <= 1'b0;
								end
								prev_q[i] <= lvl[i];
							end
						end
					end
				end
				OP_READ_DOWN: if (read_ok) down_q[sel] <= '0;
				OP_READ_UP:   if (read_ok) up_q[sel]   <= '0;
				OP_READ_TIME: if (read_ok) held_q[sel] <= '0;
				OP_SET: begin
					if (in_range) begin
						ovr_q[sel]     <= 1'b1;
						pressed_q[sel] <= set_state_q;
						held_q[sel]    <= set_time_q;
						down_q[sel]    <= set_down_q;
						up_q[sel]      <= set_up_q;
					end
				end
				OP_FLUSH: begin
					if (present_q) begin
						ovr_q     <= '0;
						pressed_q <= '0;
						for (int i = 0; i < BUTTON_COUNT; i++) begin
							held_q[i] <= '0;
							down_q[i] <= '0;
							up_q[i]   <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/button_event_tracker.sv
// Top level of the button event tracker.
//
// Input channel (in_valid/in_ready) carries one item: a tick with the sampled
// button byte and elapsed timer ticks, a read of state, press count, release
// count or held time (reads of counts and time clear them), a set that
// overrides one button, or a flush of all buttons.
// Output channel (out_valid/out_ready) returns one item per input item with
// read_value, zero for everything but reads.
// Config channel (cfg_valid/cfg_ready) writes bios_mode (index 0) and
// device_present (index 1); it is always ready. Write it only while idle.
// One item is in work at a time: the controller loads the item, executes it
// in S_EXEC and then holds its result in S_HOLD, so a new item is taken no
// sooner than the last result is taken.
// The result sits in an output register; while it waits, the next item is
// taken in the same cycle the result is taken, and a stalled receiver holds
// the block with the result stable.
// Reset clears all button state, counters, sampling state and configuration.
`default_nettype none
`include "button_event_tracker_defines.svh"
module button_event_tracker #(
	parameter int BUTTON_COUNT = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [bet_pkg::ModeW-1:0]     mode,
	input  wire logic [bet_pkg::BitsW-1:0]     button_bits,
	input  wire logic [bet_pkg::TicksW-1:0]    tick_count,
	input  wire logic [bet_pkg::IndexW-1:0]    button_index,
	input  wire logic                          set_state,
	input  wire logic [bet_pkg::TimeW-1:0]     set_time,
	input  wire logic [bet_pkg::CountW-1:0]    set_down_count,
	input  wire logic [bet_pkg::CountW-1:0]    set_up_count,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [bet_pkg::TimeW-1:0]          read_value,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bet_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic                          cfg_data
);
	import bet_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	bet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	bet_datapath #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_wr         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mode           (mode),
		.button_bits    (button_bits),
		.tick_count     (tick_count),
		.button_index   (button_index),
		.set_state      (set_state),
		.set_time       (set_time),
		.set_down_count (set_down_count),
		.set_up_count   (set_up_count),
		.read_value     (read_value)
	);

	// A waiting, stalled result blocks new items
	`BET_ASSERT_ALWAYS(a_no_accept_over_result, !(in_ready && out_valid && !out_ready))
	// Each accepted item yields its result once it has passed through S_EXEC
	`BET_ASSERT(a_result_latency, (in_valid && in_ready) |-> ##2 out_valid)
	// A result leaves only when taken
	`BET_ASSERT(a_result_taken, $fell(out_valid) |-> $past(out_ready))

endmodule
`default_nettype wire
